### rtl/assert_macros.svh
// ------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on i_clk, off during reset
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define OPD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OPD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/opd_pkg.sv
// ------------------------------------------------------------------------
// opd_pkg
// shared types, constants and helper functions of the pid response decoder
// ------------------------------------------------------------------------
package opd_pkg;

    // response length limit and length counter sizing
    localparam int MAX_RESPONSE = 128;
    localparam int LEN_W        = $clog2(MAX_RESPONSE + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_RESPONSE);

    // field widths
    localparam int CH_W    = 8;
    localparam int SEL_W   = 3;
    localparam int VALUE_W = 17;
    localparam int CNT_W   = 7;
    localparam int KEEP_DEPTH = 5;

    localparam logic [CNT_W-1:0] KEEP_LIMIT = CNT_W'(KEEP_DEPTH);
    localparam logic [CNT_W-1:0] COUNT_MAX  = 7'd127;
    localparam logic [CNT_W-1:0] NEED_LONG  = 7'd5;
    localparam logic [CNT_W-1:0] NEED_SHORT = 7'd2;

    // header match progress codes
    localparam logic [2:0] MATCH_IDLE = 3'd0;
    localparam logic [2:0] MATCH_ONE  = 3'd1;
    localparam logic [2:0] MATCH_LAST = 3'd4;
    localparam logic [2:0] MATCH_STOP = 3'd7;

    // characters of interest
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_FOUR  = 8'h34;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PROMPT = 8'h3E;

    // requested pid codes
    typedef enum logic [SEL_W-1:0] {
        PID_RPM      = 3'd0,
        PID_SPEED    = 3'd1,
        PID_COOLANT  = 3'd2,
        PID_LOAD     = 3'd3,
        PID_FUEL     = 3'd4,
        PID_THROTTLE = 3'd5,
        PID_INTAKE   = 3'd6,
        PID_MAF      = 3'd7
    } t_pid;

    // last two characters of each pid, as they appear in the header
    localparam logic [7:0] PID_HI [8] = '{8'h30, 8'h30, 8'h30, 8'h30,
                                          8'h32, 8'h31, 8'h30, 8'h31};
    localparam logic [7:0] PID_LO [8] = '{8'h43, 8'h44, 8'h35, 8'h34,
                                          8'h46, 8'h31, 8'h46, 8'h30};

    // final view of one response, scanner to value decoder
    typedef struct packed {
        logic                  hdr_found;
        logic                  len_ok;
        logic [CNT_W-1:0]      data_count;
        logic [KEEP_DEPTH-1:0][CH_W-1:0] chars;
    } t_scan_view;

    // whitespace, prompt or nul
    function automatic logic is_trim(input logic [7:0] c);
        return (c == CH_NUL) || (c == CH_PROMPT) || (c == CH_SPACE) ||
               (c == 8'h09) || (c == 8'h0A) || (c == 8'h0B) ||
               (c == 8'h0C) || (c == 8'h0D);
    endfunction

    // hex digit: {ok, nibble}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] d;
        d = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            d = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h41 && c <= 8'h46)
            d = {1'b1, 4'(c - 8'h37)};
        else if (c >= 8'h61 && c <= 8'h66)
            d = {1'b1, 4'(c - 8'h57)};
        return d;
    endfunction

    // two characters to a byte; the digit run stops at a non-hex character
    function automatic logic [7:0] hex_byte(input logic [7:0] c0, input logic [7:0] c1);
        logic [4:0] d0;
        logic [4:0] d1;
        logic [7:0] res;
        d0 = hex_digit(c0);
        d1 = hex_digit(c1);
        if (!d0[4])
            res = 8'd0;
        else if (!d1[4])
            res = {4'd0, d0[3:0]};
        else
            res = {d0[3:0], d1[3:0]};
        return res;
    endfunction

endpackage

### rtl/opd_chr_if.sv
// ------------------------------------------------------------------------
// opd_chr_if
// character channel: one response character per transaction
// ------------------------------------------------------------------------
interface opd_chr_if import opd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CH_W-1:0]  ch;
    logic             last;
    logic [SEL_W-1:0] pid_sel;

    modport source (output valid, output ch, output last, output pid_sel, input ready);
    modport sink   (input valid, input ch, input last, input pid_sel, output ready);
endinterface

### rtl/opd_res_if.sv
// ------------------------------------------------------------------------
// opd_res_if
// result channel: one decoded value per transaction
// ------------------------------------------------------------------------
interface opd_res_if import opd_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      valid_res;
    logic [SEL_W-1:0]          pid_out;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output valid_res, output pid_out, output value,
                    input ready);
    modport sink   (input valid, input valid_res, input pid_out, input value,
                    output ready);
endinterface

### rtl/obd_pid_response_decoder_unit.sv
// ------------------------------------------------------------------------
// obd_pid_response_decoder_unit
// decodes one mode 01 pid response, given as ascii characters, to a value
// ------------------------------------------------------------------------
// The unit takes one response character per cycle on i_chr and gives one
// result transaction on o_res for each character marked last. Each
// character passes an input register and then a single pass of scan logic
// that updates the response state; on the final character the same pass
// converts the captured data and loads the result register. Throughput
// is one character per cycle; input stalls only while a final character
// waits for the result register to be taken.
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module obd_pid_response_decoder_unit import opd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    opd_chr_if.sink   i_chr,
    opd_res_if.source o_res
);

    logic             r_s1_valid;
    logic [CH_W-1:0]  r_s1_ch;
    logic             r_s1_last;
    logic [SEL_W-1:0] r_s1_sel;
    logic             out_free;
    logic             s1_move;
    logic             in_ready;
    t_scan_view       view;

    // stage advance: a final character needs the result register
    assign s1_move  = r_s1_valid && (!r_s1_last || out_free);
    assign in_ready = !r_s1_valid || s1_move;
    assign i_chr.ready = in_ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_ready) begin
            r_s1_valid <= i_chr.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_chr.valid) begin
            r_s1_ch   <= i_chr.ch;
            r_s1_last <= i_chr.last;
            r_s1_sel  <= i_chr.pid_sel;
        end
    end

    // response scanner
    opd_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (s1_move),
        .i_ch    (r_s1_ch),
        .i_last  (r_s1_last),
        .i_sel   (r_s1_sel),
        .o_view  (view)
    );

    // value decoder and result register
    opd_calc u_calc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (s1_move && r_s1_last),
        .i_sel   (r_s1_sel),
        .i_view  (view),
        .o_free  (out_free),
        .o_res   (o_res)
    );

    `OPD_ASSERT_IMP(a_stall_only_on_last, !in_ready, r_s1_valid && r_s1_last,
        "input stalled without a pending final character")
    `OPD_ASSERT_IMP(a_rose_after_last, $rose(o_res.valid),
        $past(r_s1_valid && r_s1_last),
        "result appeared without a final character")
    `OPD_ASSERT_IMP(a_invalid_zero, o_res.valid && !o_res.valid_res, o_res.value == '0,
        "invalid result carries a nonzero value")

endmodule

### rtl/opd_scan.sv
// ------------------------------------------------------------------------
// opd_scan
// per-character header search, data capture and length tracking
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module opd_scan import opd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic [CH_W-1:0]  i_ch,
    input  logic             i_last,
    input  logic [SEL_W-1:0] i_sel,
    output t_scan_view       o_view
);

    logic [2:0]        r_match_pos, n_match_pos;
    logic              r_hdr_found, n_hdr_found;
    logic [CNT_W-1:0]  r_data_count, n_data_count;
    logic [CNT_W-1:0]  r_kept_count, n_kept_count;
    logic [LEN_W-1:0]  r_length_count, n_length_count;
    logic [CH_W-1:0]   r_chars [KEEP_DEPTH];
    logic [CH_W-1:0]   n_chars [KEEP_DEPTH];
    logic [CH_W-1:0]   hdr_char;

    // expected header character at the current match position
    always_comb begin
        case (r_match_pos)
            3'd0:    hdr_char = CH_FOUR;
            3'd1:    hdr_char = CH_ONE;
            3'd2:    hdr_char = CH_SPACE;
            3'd3:    hdr_char = PID_HI[i_sel];
            default: hdr_char = PID_LO[i_sel];
        endcase
    end

    // next state for the character in the input register
    always_comb begin
        n_match_pos    = r_match_pos;
        n_hdr_found    = r_hdr_found;
        n_data_count   = r_data_count;
        n_kept_count   = r_kept_count;
        n_length_count = r_length_count;
        n_chars        = r_chars;
        if (r_length_count < LEN_MAX) begin
            n_length_count = r_length_count + 1'b1;
        end
        if (r_match_pos != MATCH_STOP) begin
            if (i_ch == CH_NUL) begin
                n_match_pos = MATCH_STOP;
            end else if (!r_hdr_found) begin
                if (i_ch == hdr_char) begin
                    if (r_match_pos == MATCH_LAST) begin
                        n_hdr_found = 1'b1;
                        n_match_pos = MATCH_IDLE;
                    end else begin
                        n_match_pos = r_match_pos + 1'b1;
                    end
                end else begin
                    n_match_pos = (i_ch == CH_FOUR) ? MATCH_ONE : MATCH_IDLE;
                end
            end else if (!(r_kept_count == '0 && i_ch == CH_SPACE)) begin
                if (r_kept_count < KEEP_LIMIT) begin
                    n_chars[r_kept_count[2:0]] = i_ch;
                end
                if (r_kept_count < COUNT_MAX) begin
                    n_kept_count = r_kept_count + 1'b1;
                end
                if (!is_trim(i_ch)) begin
                    n_data_count = n_kept_count;
                end
            end
        end
    end

    // response state, cleared after the final character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_pos    <= MATCH_IDLE;
            r_hdr_found    <= 1'b0;
            r_data_count   <= '0;
            r_kept_count   <= '0;
            r_length_count <= '0;
        end else if (i_adv) begin
            if (i_last) begin
                r_match_pos    <= MATCH_IDLE;
                r_hdr_found    <= 1'b0;
                r_data_count   <= '0;
                r_kept_count   <= '0;
                r_length_count <= '0;
            end else begin
                r_match_pos    <= n_match_pos;
                r_hdr_found    <= n_hdr_found;
                r_data_count   <= n_data_count;
                r_kept_count   <= n_kept_count;
                r_length_count <= n_length_count;
            end
        end
    end

    // captured data characters, no reset
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_chars <= n_chars;
        end
    end

    // view of the response including the current character
    always_comb begin
        o_view.hdr_found  = n_hdr_found;
        o_view.len_ok     = (n_length_count < LEN_MAX);
        o_view.data_count = n_data_count;
        for (int k = 0; k < KEEP_DEPTH; k++) begin
            o_view.chars[k] = n_chars[k];
        end
    end

    `OPD_ASSERT_NXT(a_clear_after_last, i_adv && i_last,
        r_kept_count == '0 && r_length_count == '0 && !r_hdr_found,
        "response state not cleared after final character")
    `OPD_ASSERT_IMP(a_data_le_kept, 1'b1, r_data_count <= r_kept_count,
        "significant data count exceeds kept count")

endmodule

### rtl/opd_calc.sv
// ------------------------------------------------------------------------
// opd_calc
// byte conversion, per-pid scaling and the result register
// ------------------------------------------------------------------------
module opd_calc import opd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic [SEL_W-1:0] i_sel,
    input  t_scan_view       i_view,
    output logic             o_free,
    opd_res_if.source        o_res
);

    logic [7:0]          byte_a;
    logic [7:0]          byte_b;
    logic                need_long;
    logic                ok;
    logic [14:0]         pct_prod;
    logic [15:0]         pct_x1;
    logic [16:0]         pct_sum;
    logic [7:0]          pct_q;
    logic [VALUE_W-1:0]  n_value;

    logic                r_valid;
    logic                r_valid_res;
    logic [SEL_W-1:0]    r_pid;
    logic [VALUE_W-1:0]  r_value;

    // data bytes from the captured characters
    assign byte_a = hex_byte(i_view.chars[0], i_view.chars[1]);
    assign byte_b = hex_byte(i_view.chars[3], i_view.chars[4]);

    // validity of the response
    assign need_long = (t_pid'(i_sel) == PID_RPM) || (t_pid'(i_sel) == PID_MAF);
    assign ok = i_view.hdr_found && i_view.len_ok &&
                (i_view.data_count >= (need_long ? NEED_LONG : NEED_SHORT));

    // a*100/255 via reciprocal: q = (x+1 + ((x+1)>>8)) >> 8
    assign pct_prod = 15'(byte_a) * 15'd100;
    assign pct_x1   = 16'(pct_prod) + 16'd1;
    assign pct_sum  = 17'(pct_x1) + 17'(pct_x1[15:8]);
    assign pct_q    = pct_sum[15:8];

    // per-pid scaling
    always_comb begin
        n_value = '0;
        if (ok) begin
            case (t_pid'(i_sel))
                PID_RPM, PID_MAF:        n_value = {1'b0, byte_a, byte_b};
                PID_SPEED:               n_value = VALUE_W'(byte_a);
                PID_COOLANT, PID_INTAKE: n_value = VALUE_W'(byte_a) - 17'd40;
                PID_LOAD, PID_FUEL, PID_THROTTLE: n_value = VALUE_W'(pct_q);
                default:                 n_value = '0;
            endcase
        end
    end

    assign o_free = !r_valid || o_res.ready;

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_valid_res <= ok;
            r_pid       <= i_sel;
            r_value     <= n_value;
        end
    end

    assign o_res.valid     = r_valid;
    assign o_res.valid_res = r_valid_res;
    assign o_res.pid_out   = r_pid;
    assign o_res.value     = $signed(r_value);

endmodule
